/* design/i2cm_pkg.sv */
// package: types, codes and constants of the i2c master register access block
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int PHASE_COUNT_WIDTH = 16;
    localparam int TICKS_WIDTH       = 16;
    localparam int LEN_WIDTH = (PHASE_COUNT_WIDTH > TICKS_WIDTH) ?
                               PHASE_COUNT_WIDTH + 1 : TICKS_WIDTH + 1;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

    // request codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // byte stages of a transaction
    localparam logic [1:0] STAGE_WADDR = 2'd0;
    localparam logic [1:0] STAGE_REG   = 2'd1;
    localparam logic [1:0] STAGE_DATA  = 2'd2;
    localparam logic [1:0] STAGE_RADDR = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_WADDR = 2'd1,
        ERR_REG   = 2'd2,
        ERR_DATA  = 2'd3
    } t_error;

    typedef enum logic [0:0] {
        REG_DEVICE_ADDRESS = 1'b0,
        REG_PHASE_TICKS    = 1'b1
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE, S_ST0, S_ST1, S_ST2, S_ST3, S_ST4,
        S_WB0, S_WB1, S_WB2,
        S_ACK0, S_ACK1, S_ACK2, S_ACK3, S_ACK3B, S_ACK4, S_ACK4B,
        S_RD0, S_RB0, S_RB1, S_RB2, S_RB2B, S_RDE, S_RDEB,
        S_NA0, S_NA1, S_NA2,
        S_SP0, S_SP1, S_SP2, S_SP3
    } t_step;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        t_error     error_code;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        t_cfg_index  index;
        logic [15:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [6:0]             device_address;
        logic [TICKS_WIDTH-1:0] phase_ticks;
    } t_cfg_regs;

endpackage

/* design/i2cm_if.sv */
// interfaces: input item, result item and configuration write channels
`timescale 1ns / 1ps

interface i2cm_in_if;
    import i2cm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/i2cm_cfg.sv */
// configuration registers: device address and phase length
`timescale 1ns / 1ps

module i2cm_cfg import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  t_cfg_write  i_wr,
    output t_cfg_regs   o_regs
);

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;

    always_comb begin
        n_regs = r_regs;
        if (i_wr_en) begin
            unique case (i_wr.index)
                REG_DEVICE_ADDRESS: n_regs.device_address = i_wr.data[6:0];
                REG_PHASE_TICKS:    n_regs.phase_ticks    = i_wr.data[TICKS_WIDTH-1:0];
                default:            n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.device_address <= 7'd0;
            r_regs.phase_ticks    <= PHASE_TICKS_RESET;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

/* design/i2cm_seq.sv */
// bus sequencer: phase timer, step machine, shift byte and pin levels
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg_regs i_cfg,
    output t_out_item o_res
);

    t_step                        r_step, n_step;
    logic [PHASE_COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [2:0]                   r_bit, n_bit;
    logic [7:0]                   r_shift, n_shift;
    logic [7:0]                   r_held_reg, n_held_reg;
    logic [7:0]                   r_held_data, n_held_data;
    logic                         r_is_read, n_is_read;
    t_error                       r_err, n_err;
    logic [1:0]                   r_stage, n_stage;
    logic [7:0]                   r_rd, n_rd;
    logic                         r_scl, n_scl;
    logic                         r_sda, n_sda;
    logic                         r_drive, n_drive;
    logic                         done;

    logic                 busy;
    logic                 start;
    logic                 wrap;
    logic                 adv;
    logic [LEN_WIDTH-1:0] ticks_ext;
    logic [LEN_WIDTH-1:0] lim;
    logic [LEN_WIDTH-1:0] len;
    logic [LEN_WIDTH-1:0] cnt_inc;
    logic [1:0]           stage_inc;
    logic [7:0]           cur_byte;
    logic [7:0]           inc_byte;

    function automatic logic [7:0] byte_for_stage(input logic [1:0] s,
                                                  input logic [6:0] dev,
                                                  input logic [7:0] rg,
                                                  input logic [7:0] dt);
        logic [7:0] b;
        case (s)
            STAGE_WADDR: b = {dev, 1'b0};
            STAGE_REG:   b = rg;
            STAGE_DATA:  b = dt;
            default:     b = {dev, 1'b1};
        endcase
        return b;
    endfunction

    // phase timer, zero length runs as one tick
    assign ticks_ext = LEN_WIDTH'(i_cfg.phase_ticks);
    assign lim       = LEN_WIDTH'(1) << PHASE_COUNT_WIDTH;
    assign len       = (i_cfg.phase_ticks == '0) ? LEN_WIDTH'(1) :
                       ((ticks_ext > lim) ? lim : ticks_ext);
    assign cnt_inc   = LEN_WIDTH'(r_cnt) + LEN_WIDTH'(1);
    assign busy      = (r_step != S_IDLE);
    assign start     = !busy && ((i_item.operation == OP_WRITE) ||
                                 (i_item.operation == OP_READ));
    assign wrap      = !(cnt_inc < len);
    assign adv       = busy && wrap;
    assign stage_inc = r_stage + 2'd1;
    assign cur_byte  = byte_for_stage(r_stage, i_cfg.device_address,
                                      r_held_reg, r_held_data);
    assign inc_byte  = byte_for_stage(stage_inc, i_cfg.device_address,
                                      r_held_reg, r_held_data);

    // next step
    always_comb begin
        n_step = r_step;
        if (start) begin
            n_step = S_ST0;
        end else if (adv) begin
            unique case (r_step)
                S_ST0:   n_step = S_ST1;
                S_ST1:   n_step = S_ST2;
                S_ST2:   n_step = S_ST3;
                S_ST3:   n_step = S_ST4;
                S_ST4:   n_step = S_WB0;
                S_WB0:   n_step = S_WB1;
                S_WB1:   n_step = S_WB2;
                S_WB2:   n_step = (r_bit != 3'd7) ? S_WB0 : S_ACK0;
                S_ACK0:  n_step = S_ACK1;
                S_ACK1:  n_step = S_ACK2;
                S_ACK2:  n_step = S_ACK3;
                S_ACK3:  n_step = S_ACK3B;
                S_ACK3B: n_step = S_ACK4;
                S_ACK4:  n_step = S_ACK4B;
                S_ACK4B: begin
                    if (r_err != ERR_NONE || r_stage == STAGE_DATA) begin
                        n_step = S_SP0;
                    end else if (r_stage == STAGE_RADDR) begin
                        n_step = S_RD0;
                    end else if (r_stage == STAGE_REG && r_is_read) begin
                        n_step = S_ST0;
                    end else begin
                        n_step = S_WB0;
                    end
                end
                S_RD0:   n_step = S_RB0;
                S_RB0:   n_step = S_RB1;
                S_RB1:   n_step = S_RB2;
                S_RB2:   n_step = S_RB2B;
                S_RB2B:  n_step = (r_bit != 3'd7) ? S_RB0 : S_RDE;
                S_RDE:   n_step = S_RDEB;
                S_RDEB:  n_step = S_NA0;
                S_NA0:   n_step = S_NA1;
                S_NA1:   n_step = S_NA2;
                S_NA2:   n_step = S_SP0;
                S_SP0:   n_step = S_SP1;
                S_SP1:   n_step = S_SP2;
                S_SP2:   n_step = S_SP3;
                default: n_step = S_IDLE;
            endcase
        end
    end

    // pins, counters and data
    always_comb begin
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_is_read   = r_is_read;
        n_err       = r_err;
        n_stage     = r_stage;
        n_rd        = r_rd;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_drive     = r_drive;
        done        = 1'b0;
        if (start) begin
            n_held_reg = i_item.reg_address;
            if (i_item.operation == OP_WRITE) begin
                n_held_data = i_item.write_data;
            end
            n_is_read = (i_item.operation == OP_READ);
            n_err     = ERR_NONE;
            n_stage   = STAGE_WADDR;
            n_bit     = 3'd0;
            n_shift   = 8'd0;
            n_cnt     = '0;
            n_scl     = 1'b0;
            n_sda     = 1'b0;
            n_drive   = 1'b1;
        end else if (busy && !wrap) begin
            n_cnt = cnt_inc[PHASE_COUNT_WIDTH-1:0];
        end else if (adv) begin
            n_cnt = '0;
            unique case (r_step)
                S_ST0: n_sda = 1'b1;
                S_ST1: n_scl = 1'b1;
                S_ST2: n_sda = 1'b0;
                S_ST3: n_scl = 1'b0;
                S_ST4: begin
                    n_bit   = 3'd0;
                    n_shift = cur_byte;
                    n_sda   = cur_byte[7];
                    n_drive = 1'b1;
                end
                S_WB0: n_scl = 1'b1;
                S_WB1: n_scl = 1'b0;
                S_WB2: begin
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_sda   = r_shift[6];
                        n_drive = 1'b1;
                    end else begin
                        n_drive = 1'b0;
                    end
                end
                S_ACK0: n_scl = 1'b1;
                S_ACK1: begin
                    // sda high during the ack clock is a nack
                    if (i_item.sda_in) begin
                        case (r_stage)
                            STAGE_WADDR: n_err = ERR_WADDR;
                            STAGE_REG:   n_err = ERR_REG;
                            default:     n_err = ERR_DATA;
                        endcase
                    end
                end
                S_ACK2:  n_scl   = 1'b0;
                S_ACK3B: n_drive = 1'b1;
                S_ACK4B: begin
                    if (r_err != ERR_NONE || r_stage == STAGE_DATA) begin
                        n_sda = 1'b0;
                    end else if (r_stage == STAGE_RADDR) begin
                        n_drive = 1'b0;
                        n_bit   = 3'd0;
                        n_shift = 8'd0;
                    end else if (r_stage == STAGE_REG && r_is_read) begin
                        n_stage = STAGE_RADDR;
                        n_scl   = 1'b0;
                    end else begin
                        n_stage = stage_inc;
                        n_bit   = 3'd0;
                        n_shift = inc_byte;
                        n_sda   = inc_byte[7];
                        n_drive = 1'b1;
                    end
                end
                S_RD0: n_scl   = 1'b1;
                S_RB0: n_shift = {r_shift[6:0], i_item.sda_in};
                S_RB1: n_scl   = 1'b0;
                S_RB2B: begin
                    if (r_bit != 3'd7) begin
                        n_bit = r_bit + 3'd1;
                        n_scl = 1'b1;
                    end else begin
                        n_drive = 1'b1;
                        n_rd    = r_shift;
                    end
                end
                S_RDEB: n_sda = 1'b1;
                S_NA0:  n_scl = 1'b1;
                S_NA1:  n_scl = 1'b0;
                S_NA2:  n_sda = 1'b0;
                S_SP0:  n_scl = 1'b1;
                S_SP1:  n_sda = 1'b1;
                S_SP2:  n_scl = 1'b0;
                S_SP3:  done  = 1'b1;
                default: done = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_cnt       <= '0;
            r_bit       <= 3'd0;
            r_shift     <= 8'd0;
            r_held_reg  <= 8'd0;
            r_held_data <= 8'd0;
            r_is_read   <= 1'b0;
            r_err       <= ERR_NONE;
            r_stage     <= STAGE_WADDR;
            r_rd        <= 8'd0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_drive     <= 1'b0;
        end else if (i_en) begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_held_reg  <= n_held_reg;
            r_held_data <= n_held_data;
            r_is_read   <= n_is_read;
            r_err       <= n_err;
            r_stage     <= n_stage;
            r_rd        <= n_rd;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_drive     <= n_drive;
        end
    end

    always_comb begin
        o_res.scl_level  = n_scl;
        o_res.sda_level  = n_sda;
        o_res.sda_drive  = n_drive;
        o_res.busy_res   = (n_step != S_IDLE);
        o_res.done_res   = done;
        o_res.error_code = n_err;
        o_res.read_data  = n_rd;
    end

    // the stop leaves scl low, so the bus clock is low whenever idle
    a_idle_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_IDLE) |-> !r_scl)
        else $error("scl high while idle");

    // a taken request opens the start phase with sda driven and a fresh timer
    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && start) |=> (r_step == S_ST0 && r_drive && r_cnt == '0))
        else $error("request did not open start phase");

    // the read address stage is reached only in a read transaction
    a_read_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == STAGE_RADDR) |-> r_is_read)
        else $error("read address stage in a write");

    // the final stop phase returns to idle
    a_stop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && adv && r_step == S_SP3) |=> (r_step == S_IDLE))
        else $error("transaction did not end after stop");

endmodule

/* design/i2c_master_register_access_core.sv */
// top level: i2c master for single register write and read transactions
`timescale 1ns / 1ps

// channel   direction  payload                                          handshake
// i_in      sink       operation, reg_address, write_data, sda_in       valid/ready
// o_out     source     scl, sda, drive, busy, done, error, read_data    valid/ready
// i_cfg     sink       register index, write data                       valid/ready, ready high
//
// one item per cycle: each item is one bus tick, handled in the cycle it is taken
// the result stands in an output register, a new item is taken while it is consumed
// o_out stalled with a result pending holds i_in.ready low, the sequencer freezes
// synchronous active-low reset: idle, pins low, sda released, phase_ticks 100
// every item gives exactly one result item

module i2c_master_register_access_core import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_in_if.sink    i_in,
    i2cm_out_if.source o_out,
    i2cm_cfg_if.sink   i_cfg
);

    t_cfg_regs cfg_regs;
    t_out_item seq_res;
    logic      in_accept;
    logic      cfg_accept;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    // take an item when the result slot is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    i2cm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (cfg_accept),
        .i_wr    (i_cfg.data),
        .o_regs  (cfg_regs)
    );

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_accept),
        .i_item  (i_in.data),
        .i_cfg   (cfg_regs),
        .o_res   (seq_res)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= seq_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
